FILE: rtl/melody_note_sequencer_core_defines.svh
// Assertion helpers used by the checker module mns_chk.
`ifndef MELODY_NOTE_SEQUENCER_CORE_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_CORE_DEFINES_SVH

// Next-cycle implication, switched off while reset is asserted.
`define MNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication, switched off while reset is asserted.
`define MNS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define MNS_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mns_pkg.sv
package mns_pkg;

  localparam int unsigned MAX_NOTES_DEF = 64;

  localparam int unsigned TEMPO_W = 9;
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned PITCH_W = 15;
  localparam int unsigned MS_W    = 22;
  localparam int unsigned DSR_W   = TEMPO_W + VALUE_W;

  // full length = LEN_NUM / (tempo * value), one quotient bit per step
  localparam logic [MS_W-1:0] LEN_NUM   = 22'd3840000;
  localparam int unsigned     DIV_STEPS = MS_W;
  localparam int unsigned     CNT_W     = $clog2(DIV_STEPS);

  // break = min(full * 15 / 100, 200); the cap applies from 1334 ms upwards
  localparam logic [MS_W-1:0] BREAK_CAP   = 22'd200;
  localparam logic [MS_W-1:0] BRK_BIG_LIM = 22'd1334;
  localparam int unsigned     BRK_X_W     = 15;
  localparam int unsigned     RECIP_SH    = 21;
  localparam logic [BRK_X_W-1:0] RECIP_M  = 15'd20972;
  localparam int unsigned     BRK_PROD_W  = 2 * BRK_X_W;

  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 9'd120;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_TEMPO = 1'b0;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [VALUE_W-1:0] note_value;
    logic [PITCH_W-1:0] frequency_hz;
    logic               legato;
  } in_item_t;

  typedef struct packed {
    logic [PITCH_W-1:0] tone_hz;
    logic [MS_W-1:0]    play_ms;
  } out_item_t;

  typedef struct packed {
    logic [MS_W-1:0]    play;
    logic [MS_W-1:0]    total;
    logic [PITCH_W-1:0] pitch;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_BRK,
    ST_STORE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic tick;
    logic rd;
    logic mul;
    logic div_step;
    logic brk;
    logic store;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic tick_hit;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/mns_ctrl.sv
module mns_ctrl import mns_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  input  sts_t       sts,
  output logic       in_stall,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FUNC_LOAD: begin
              if (!sts.full) state_nxt = ST_MUL;
            end
            FUNC_TICK: begin
              if (sts.tick_hit) state_nxt = ST_EMIT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_BRK;
      end
      ST_BRK:   state_nxt = ST_STORE;
      ST_STORE: state_nxt = ST_IDLE;
      ST_EMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FUNC_CLEAR: cmd.clear = 1'b1;
            FUNC_LOAD:  cmd.capture = !sts.full;
            FUNC_TICK: begin
              cmd.tick = 1'b1;
              cmd.rd   = sts.tick_hit;
            end
            default: cmd = '0;
          endcase
        end
      end
      ST_MUL:   cmd.mul      = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_BRK:   cmd.brk      = 1'b1;
      ST_STORE: cmd.store    = 1'b1;
      ST_EMIT:  cmd.emit     = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

FILE: rtl/mns_dp.sv
module mns_dp import mns_pkg::*; #(
  parameter int unsigned MAX_NOTES = MAX_NOTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [TEMPO_W-1:0] tempo,
  input  in_item_t           in_data,
  input  cmd_t               cmd,
  input  logic               out_stall,
  output sts_t               sts,
  output logic               out_valid,
  output out_item_t          out_data
);

  localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned CW = $clog2(MAX_NOTES + 1);

  // captured note
  logic [VALUE_W-1:0] value_r;
  logic [PITCH_W-1:0] pitch_r;
  logic               legato_r;

  // length divider
  logic [DSR_W-1:0]   prod_r;
  logic [DSR_W-1:0]   rem_r;
  logic [MS_W-1:0]    dvd_r;
  logic [MS_W-1:0]    quo_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [DSR_W-1:0]   dsr;
  logic [DSR_W:0]     rem_sh;
  logic [DSR_W:0]     rem_diff;
  logic               take;

  // break
  logic [BRK_X_W-1:0]    brk_x;
  logic [BRK_PROD_W-1:0] brk_prod_r;
  logic                  brk_big_r;
  logic [MS_W-1:0]       brk_ms;
  logic [MS_W-1:0]       play_ms;

  // store and sequencer
  entry_t            mem [MAX_NOTES];
  entry_t            rd_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     index_r;
  logic [MS_W-1:0]   wait_r;
  logic [MS_W-1:0]   wait_dec;
  logic              more;

  logic              out_valid_r;
  out_item_t         out_data_r;

  assign dsr      = (prod_r == '0) ? DSR_W'(1) : prod_r;
  assign rem_sh   = {rem_r, dvd_r[MS_W-1]};
  assign rem_diff = rem_sh - {1'b0, dsr};
  assign take     = (rem_sh >= {1'b0, dsr});

  assign brk_x   = (quo_r[BRK_X_W-1:0] << 4) - quo_r[BRK_X_W-1:0];
  assign brk_ms  = brk_big_r ? BREAK_CAP : MS_W'(brk_prod_r[BRK_PROD_W-1:RECIP_SH]);
  assign play_ms = legato_r ? quo_r : (quo_r - brk_ms);

  assign wait_dec = (wait_r != '0) ? (wait_r - MS_W'(1)) : wait_r;
  assign more     = (index_r < count_r);

  assign sts.full     = (count_r == CW'(MAX_NOTES));
  assign sts.tick_hit = (wait_dec == '0) && more;
  assign sts.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      value_r  <= in_data.note_value;
      pitch_r  <= in_data.frequency_hz;
      legato_r <= in_data.legato;
    end
    if (cmd.mul) begin
      prod_r <= {{(DSR_W-TEMPO_W){1'b0}}, tempo} * {{(DSR_W-VALUE_W){1'b0}}, value_r};
      rem_r  <= '0;
      dvd_r  <= LEN_NUM;
    end
    if (cmd.div_step) begin
      rem_r <= take ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      quo_r <= {quo_r[MS_W-2:0], take};
      dvd_r <= {dvd_r[MS_W-2:0], 1'b0};
    end
    if (cmd.brk) begin
      brk_prod_r <= {{BRK_X_W{1'b0}}, brk_x} * {{BRK_X_W{1'b0}}, RECIP_M};
      brk_big_r  <= (quo_r >= BRK_BIG_LIM);
    end
    if (cmd.emit) begin
      out_data_r <= '{tone_hz: rd_r.pitch, play_ms: rd_r.play};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count_r[AW-1:0]] <= '{play: play_ms, total: quo_r, pitch: pitch_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_r <= mem[index_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      count_r     <= '0;
      index_r     <= '0;
      wait_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul) begin
        cnt_r <= '0;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end

      if (cmd.clear) begin
        count_r <= '0;
        index_r <= '0;
        wait_r  <= '0;
      end else if (cmd.store) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.tick) begin
        wait_r <= wait_dec;
        if ((wait_dec == '0) && !more) begin
          index_r <= '0;
        end
      end else if (cmd.emit) begin
        wait_r  <= rd_r.total;
        index_r <= index_r + CW'(1);
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/melody_note_sequencer_core.sv
// Melody note sequencer.
// Input channel (in_valid / in_stall / in_data): one beat carries a command.
//   Clear empties the note store and rewinds playback.
//   Load computes the note length by a 22-step restoring divider and writes
//   the store; in_stall stays high through the multiply, divide, break and
//   store states. A load into a full store is dropped.
//   Tick (one millisecond) counts down the wait; on a note start the
//   stored note is read and placed in the output register.
// Output channel (out_valid / out_stall / out_data): one beat per note start
//   carrying its pitch and play time, loaded in the emit state after the tick.
//   A stalled beat holds; further commands are still taken, and a second
//   note start waits (in_stall high) until the output register frees.
// APB port: tempo register at byte address 0, reads back, pready tied high.
//   Write it only while the block is idle.
// Reset (rst_n low, synchronous): empty store, index and wait zero,
//   tempo 120, output empty. The store itself is not cleared.
module melody_note_sequencer_core import mns_pkg::*; #(
  parameter int unsigned MAX_NOTES = MAX_NOTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  logic [TEMPO_W-1:0] tempo_r;
  logic               reg_hit;
  cmd_t               cmd;
  sts_t               sts;

  // Register decode: word index lives above the byte offset
  assign reg_hit = (paddr[CFG_AW-1:2] == REG_TEMPO);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? CFG_DW'(tempo_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r <= TEMPO_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tempo_r <= pwdata[TEMPO_W-1:0];
    end
  end

  // Sequencer control: decode the beat, step the divider, hand out notes
  mns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Arithmetic, note store, playback counters and output register
  mns_dp #(
    .MAX_NOTES (MAX_NOTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .tempo     (tempo_r),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/mns_chk.sv
`include "melody_note_sequencer_core_defines.svh"

module mns_chk import mns_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `MNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "out beat dropped")
  `MNS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "out moved")
  `MNS_ASSERT_NEXT(a_clear_fast, clk, rst_n, in_valid && !in_stall && (in_data.func == FUNC_CLEAR), !in_stall, "clear stalled")
  `MNS_ASSERT_NOW(a_emit_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "note start while idle")
  `MNS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid, "out beat after reset")

endmodule

bind melody_note_sequencer_core mns_chk u_mns_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
